// ===== hw/rtl/skf_pkg.sv =====
// skf_pkg: payload types, register indexes, micro-op codes and the
// control store of the scalar kalman filter sequencer.
// no dependencies; imported by skf_useq and scalar_kalman_filter.
package skf_pkg;

  localparam int XW   = 32;   // estimate, q16.16 signed
  localparam int PW   = 31;   // covariance and noise, q15.16 unsigned
  localparam int KW   = 17;   // gain, q1.16
  localparam int SW   = 32;   // covariance plus measurement noise
  localparam int DW   = 33;   // measurement minus estimate
  localparam int MAW  = 18;   // multiplier operand a
  localparam int MBW  = 34;   // multiplier operand b
  localparam int MPW  = MAW + MBW;
  localparam int CFG_DW = 32;
  localparam int CFG_IW = 2;

  localparam logic [PW-1:0] MAX_P = {PW{1'b1}};
  localparam logic [KW-1:0] ONE_K = KW'(65536);

  localparam logic [PW-1:0] RST_Q      = PW'(655);
  localparam logic [PW-1:0] RST_R      = PW'(65536);
  localparam logic [PW-1:0] RST_INIT_P = PW'(65536);
  localparam logic [PW-1:0] RST_COV    = PW'(65536);

  // quotient bits of the gain division, one per step
  localparam int DIV_STEPS = KW;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_PROCESS_NOISE      = 2'd0;
  localparam logic [CFG_IW-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_INITIAL_ESTIMATE   = 2'd2;
  localparam logic [CFG_IW-1:0] REG_INITIAL_COVARIANCE = 2'd3;

  typedef struct packed {
    logic                 kind;
    logic signed [XW-1:0] measurement;
  } in_t;

  typedef struct packed {
    logic signed [XW-1:0] estimate;
    logic [KW-1:0]        gain;
    logic [PW-1:0]        covariance;
  } out_t;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_REINIT = 1'b1;

  // datapath micro-ops
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
  localparam logic [OP_W-1:0] OP_ADDQ   = 4'd1;
  localparam logic [OP_W-1:0] OP_ADDR   = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV    = 4'd3;
  localparam logic [OP_W-1:0] OP_DIFF   = 4'd4;
  localparam logic [OP_W-1:0] OP_MULX   = 4'd5;
  localparam logic [OP_W-1:0] OP_UPDX   = 4'd6;
  localparam logic [OP_W-1:0] OP_MULP   = 4'd7;
  localparam logic [OP_W-1:0] OP_UPDP   = 4'd8;
  localparam logic [OP_W-1:0] OP_REINIT = 4'd9;
  localparam logic [OP_W-1:0] OP_EMIT   = 4'd10;

  // sequencing conditions
  localparam int CND_W = 3;
  localparam logic [CND_W-1:0] CND_NEXT     = 3'd0;
  localparam logic [CND_W-1:0] CND_DISPATCH = 3'd1;
  localparam logic [CND_W-1:0] CND_SZERO    = 3'd2;
  localparam logic [CND_W-1:0] CND_LOOP     = 3'd3;
  localparam logic [CND_W-1:0] CND_JUMP     = 3'd4;
  localparam logic [CND_W-1:0] CND_EMIT     = 3'd5;

  // program steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] ST_ADDQ   = 4'd1;
  localparam logic [STEP_W-1:0] ST_ADDR   = 4'd2;
  localparam logic [STEP_W-1:0] ST_DIV    = 4'd3;
  localparam logic [STEP_W-1:0] ST_DIFF   = 4'd4;
  localparam logic [STEP_W-1:0] ST_MULX   = 4'd5;
  localparam logic [STEP_W-1:0] ST_UPDX   = 4'd6;
  localparam logic [STEP_W-1:0] ST_MULP   = 4'd7;
  localparam logic [STEP_W-1:0] ST_UPDP   = 4'd8;
  localparam logic [STEP_W-1:0] ST_REINIT = 4'd9;
  localparam logic [STEP_W-1:0] ST_EMIT   = 4'd10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CND_W-1:0]  cnd;
    logic [STEP_W-1:0] target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idle;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_fire;
    logic kind;
    logic s_zero;
    logic emit_ok;
  } stat_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      ST_IDLE:   w = '{OP_NOP,    CND_DISPATCH, ST_REINIT};
      ST_ADDQ:   w = '{OP_ADDQ,   CND_NEXT,     ST_IDLE};
      // zero sum skips the division, gain stays cleared
      ST_ADDR:   w = '{OP_ADDR,   CND_SZERO,    ST_DIFF};
      ST_DIV:    w = '{OP_DIV,    CND_LOOP,     ST_DIV};
      ST_DIFF:   w = '{OP_DIFF,   CND_NEXT,     ST_IDLE};
      ST_MULX:   w = '{OP_MULX,   CND_NEXT,     ST_IDLE};
      ST_UPDX:   w = '{OP_UPDX,   CND_NEXT,     ST_IDLE};
      ST_MULP:   w = '{OP_MULP,   CND_NEXT,     ST_IDLE};
      ST_UPDP:   w = '{OP_UPDP,   CND_JUMP,     ST_EMIT};
      ST_REINIT: w = '{OP_REINIT, CND_NEXT,     ST_IDLE};
      ST_EMIT:   w = '{OP_EMIT,   CND_EMIT,     ST_IDLE};
      default:   w = '{OP_NOP,    CND_JUMP,     ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/skf_useq.sv =====
// skf_useq: step counter, control store lookup and jump logic.
// depends on skf_pkg for the program and the control structs.
module skf_useq (
  input  logic          clk,
  input  logic          rst_n,
  input  skf_pkg::stat_t stat,
  output skf_pkg::ctrl_t ctrl
);
  import skf_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  uword_t            uw;

  assign uw        = ucode(step_r);
  assign ctrl.op   = uw.op;
  assign ctrl.idle = (step_r == ST_IDLE);

  always_comb begin
    step_nxt = step_r + STEP_W'(1);
    unique case (uw.cnd)
      CND_NEXT: step_nxt = step_r + STEP_W'(1);
      CND_DISPATCH: begin
        if (!stat.in_fire) begin
          step_nxt = step_r;
        end else if (stat.kind == KIND_REINIT) begin
          step_nxt = uw.target;
        end
      end
      CND_SZERO: begin
        if (stat.s_zero) begin
          step_nxt = uw.target;
        end
      end
      CND_LOOP: begin
        if (cnt_r != '0) begin
          step_nxt = uw.target;
        end
      end
      CND_JUMP: step_nxt = uw.target;
      CND_EMIT: step_nxt = stat.emit_ok ? uw.target : step_r;
      default:  step_nxt = ST_IDLE;
    endcase
  end

  // quotient bit counter for the divide loop
  always_comb begin
    cnt_nxt = cnt_r;
    if (uw.op == OP_ADDR) begin
      cnt_nxt = CNT_W'(DIV_STEPS - 1);
    end else if (uw.op == OP_DIV && cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
      cnt_r  <= '0;
    end else begin
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_loop_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_DIV && cnt_r == '0) |=> (step_r == ST_DIFF))
    else $error("divide loop did not exit");

  a_div_after_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_ADDR && !stat.s_zero) |=> (step_r == ST_DIV && cnt_r == CNT_W'(DIV_STEPS - 1)))
    else $error("divide loop not started with full count");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DIV_STEPS - 1))
    else $error("divide counter out of range");

endmodule

// ===== hw/rtl/scalar_kalman_filter.sv =====
// scalar_kalman_filter: top level, configuration registers and datapath
// (adder, restoring divider, shared multiplier) driven by skf_useq.
// depends on skf_pkg and skf_useq.
//
//  channel | direction | handshake           | beat
//  in      | input     | in_valid / in_stall   | in_t: kind, measurement
//  out     | output    | out_valid / out_stall | out_t: estimate, gain, covariance
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// an update runs add q, add r, the one-bit-a-step gain divide (skipped when
// p + r is zero), diff, multiply and update of x and p, then emit; reinitialize
// loads and emits; the next beat is taken the cycle after the result is loaded.
// one item at a time: in_stall is high from accept until the result is
// loaded into the output register; a stalled output holds the sequencer.
// reset is synchronous: estimate 0, covariance one, gain 0, registers defaults.
module scalar_kalman_filter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  skf_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output skf_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic [skf_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [skf_pkg::CFG_DW-1:0]   cfg_data
);
  import skf_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // configuration
  logic [PW-1:0]        q_r, r_r, init_p_r;
  logic signed [XW-1:0] init_x_r;

  // filter state
  logic signed [XW-1:0] x_r;
  logic [PW-1:0]        cov_r;
  logic [KW-1:0]        gain_r;

  // working registers
  logic signed [XW-1:0] z_r;
  logic [PW-1:0]        p_r;
  logic [SW-1:0]        s_r;
  logic [SW:0]          rem_r;
  logic [KW-1:0]        k_r;
  logic [DW-1:0]        d_r;
  logic signed [MPW-1:0] prod_r;

  logic                 out_valid_r;
  out_t                 out_data_r;

  logic                 in_fire, emit_ok, emit;
  logic [SW-1:0]        sum_q;
  logic [SW:0]          rem_sub;
  logic                 ge;
  logic [SW:0]          rem_d;
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;

  skf_useq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign in_stall  = !ctrl.idle;
  assign in_fire   = in_valid && ctrl.idle;
  assign emit_ok   = !out_valid_r || !out_stall;
  assign emit      = (ctrl.op == OP_EMIT) && emit_ok;

  assign stat.in_fire = in_fire;
  assign stat.kind    = in_data.kind;
  assign stat.s_zero  = (p_r == '0) && (r_r == '0);
  assign stat.emit_ok = emit_ok;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // saturating p + q
  assign sum_q = {1'b0, cov_r} + {1'b0, q_r};

  // restoring divide step, remainder always below the divisor afterwards
  assign rem_sub = rem_r - {1'b0, s_r};
  assign ge      = (rem_r >= {1'b0, s_r});
  assign rem_d   = ge ? rem_sub : rem_r;

  // shared multiplier operands
  always_comb begin
    if (ctrl.op == OP_MULP) begin
      mul_a = {1'b0, ONE_K - k_r};
      mul_b = {3'b000, p_r};
    end else begin
      mul_a = {1'b0, k_r};
      mul_b = {d_r[DW-1], d_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r      <= RST_Q;
      r_r      <= RST_R;
      init_x_r <= '0;
      init_p_r <= RST_INIT_P;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROCESS_NOISE:      q_r      <= cfg_data[PW-1:0];
        REG_MEASUREMENT_NOISE:  r_r      <= cfg_data[PW-1:0];
        REG_INITIAL_ESTIMATE:   init_x_r <= cfg_data;
        REG_INITIAL_COVARIANCE: init_p_r <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // filter state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= '0;
      cov_r       <= RST_COV;
      gain_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_UPDX: x_r <= x_r + prod_r[XW+15:16];
        OP_UPDP: begin
          cov_r  <= prod_r[PW+15:16];
          gain_r <= k_r;
        end
        OP_REINIT: begin
          x_r    <= init_x_r;
          cov_r  <= init_p_r;
          gain_r <= '0;
        end
        default: ;
      endcase
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      z_r <= in_data.measurement;
    end
    unique case (ctrl.op)
      OP_ADDQ: p_r <= sum_q[SW-1] ? MAX_P : sum_q[PW-1:0];
      OP_ADDR: begin
        s_r   <= {1'b0, p_r} + {1'b0, r_r};
        rem_r <= {2'b00, p_r};
        k_r   <= '0;
      end
      OP_DIV: begin
        k_r   <= {k_r[KW-2:0], ge};
        rem_r <= {rem_d[SW-1:0], 1'b0};
      end
      OP_DIFF: d_r <= {z_r[XW-1], z_r} - {x_r[XW-1], x_r};
      OP_MULX, OP_MULP: prod_r <= mul_a * mul_b;
      default: ;
    endcase
    if (emit) begin
      out_data_r.estimate   <= x_r;
      out_data_r.gain       <= gain_r;
      out_data_r.covariance <= cov_r;
    end
  end

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.op == OP_EMIT))
    else $error("result appeared without an emit step");

  a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_UPDP) |=> (cov_r <= $past(p_r)))
    else $error("covariance grew in the update");

  a_gain_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_UPDP) |-> (k_r <= ONE_K))
    else $error("gain above one");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DIV) |-> (s_r != '0))
    else $error("divide with zero divisor");

endmodule
